### rtl/core/prdr_pkg.sv
// package with the word types, decode phases and constants of the packbits row decoder
package prdr_pkg;

    localparam logic [15:0] MAX_ROW_LENGTH = 16'd65535;
    localparam logic [15:0] ROW_LENGTH_RST = 16'd1024;
    localparam logic [7:0]  HDR_NOP        = 8'd128;
    localparam logic [7:0]  RUN_BASE       = 8'd1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    localparam int unsigned PADDR_W    = 3;
    localparam logic        REG_ROW_LEN = 1'b0;

    typedef struct packed {
        logic [7:0] coded_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [15:0] write_position;
        logic [7:0]  write_value;
        logic [7:0]  repeat_count;
        logic        row_done;
        logic [15:0] written_count;
        logic        row_short;
    } out_word_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_RUN     = 3'b010,
        PH_LITERAL = 3'b100
    } phase_t;

endpackage

### rtl/core/prdr_if.sv
// stream interfaces for coded input bytes and decoded result words
interface prdr_byte_if;
    import prdr_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface prdr_wr_if;
    import prdr_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/packbits_rle_row_decoder_unit.sv
// packbits row decoder: header/run/literal decode with a four-word result queue
// output: a result word enters the queue as its coded byte is accepted and leaves in order
// throughput: one coded byte per cycle while two queue slots are free; a row's last byte
// yields a status word after any data word; the queue drains one per cycle on out_ch.ready
// reset: rst_n clears decode state, queue and sets row_length to 1024
module packbits_rle_row_decoder_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    prdr_byte_if.sink                      in_ch,
    prdr_wr_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prdr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import prdr_pkg::*;

    logic [15:0] row_length_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  run_length_reg, run_length_next;
    logic [7:0]  literal_left_reg, literal_left_next;
    logic        literal_dropping_reg, literal_dropping_next;
    logic [15:0] row_position_reg, row_position_next;
    logic [7:0]  literal_offset_reg, literal_offset_next;

    out_word_t             queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   head_reg, tail_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;

    logic        in_acc;
    logic        out_acc;
    logic [15:0] len;
    logic [16:0] len_x;
    logic [16:0] pos_x;
    logic [16:0] lit_at;
    logic [7:0]  b;
    logic        last;
    logic        data_vld;
    out_word_t   data_word;
    out_word_t   stat_word;
    logic [QUEUE_AW:0] push_cnt;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROW_LEN) ? {16'd0, row_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_RST;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_ROW_LEN)
        begin
            row_length_reg <= pwdata[15:0];
        end
    end

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign b       = in_ch.data.coded_byte;
    assign last    = in_ch.data.last_byte;
    assign len     = (row_length_reg > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : row_length_reg;
    assign len_x   = {1'b0, len};
    assign pos_x   = {1'b0, row_position_reg};
    assign lit_at  = pos_x + {9'd0, literal_offset_reg};

    // decode of one coded byte
    always_comb
    begin
        phase_next            = phase_reg;
        run_length_next       = run_length_reg;
        literal_left_next     = literal_left_reg;
        literal_dropping_next = literal_dropping_reg;
        row_position_next     = row_position_reg;
        literal_offset_next   = literal_offset_reg;
        data_vld              = 1'b0;
        data_word             = '0;
        stat_word             = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (row_position_reg < len && !last && b != HDR_NOP)
                begin
                    if (b > HDR_NOP)
                    begin
                        run_length_next = RUN_BASE - b;
                        phase_next      = PH_RUN;
                    end
                    else
                    begin
                        literal_left_next     = b + 8'd1;
                        literal_offset_next   = 8'd0;
                        literal_dropping_next = (pos_x + {9'd0, b} + 17'd1) > len_x;
                        phase_next            = PH_LITERAL;
                    end
                end
            end
            PH_RUN:
            begin
                phase_next = PH_HEADER;
                data_word.write_position = row_position_reg;
                data_word.write_value    = b;
                if (pos_x + {9'd0, run_length_reg} <= len_x)
                begin
                    data_vld                 = 1'b1;
                    data_word.repeat_count   = run_length_reg;
                    row_position_next        = row_position_reg + {8'd0, run_length_reg};
                end
                else if (len > row_position_reg)
                begin
                    data_vld               = 1'b1;
                    data_word.repeat_count = 8'(len - row_position_reg);
                end
            end
            PH_LITERAL:
            begin
                data_word.write_position = lit_at[15:0];
                data_word.write_value    = b;
                data_word.repeat_count   = 8'd1;
                data_vld                 = !literal_dropping_reg || lit_at < len_x;
                literal_offset_next      = literal_offset_reg + 8'd1;
                literal_left_next        = literal_left_reg - 8'd1;
                if (literal_left_reg == 8'd1)
                begin
                    if (!literal_dropping_reg)
                    begin
                        row_position_next = row_position_reg + {8'd0, literal_offset_next};
                    end
                    literal_dropping_next = 1'b0;
                    phase_next            = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        if (last)
        begin
            stat_word.row_done      = 1'b1;
            stat_word.written_count = row_position_next;
            stat_word.row_short     = row_position_next < len;
            phase_next              = PH_HEADER;
            run_length_next         = 8'd0;
            literal_left_next       = 8'd0;
            literal_dropping_next   = 1'b0;
            row_position_next       = 16'd0;
            literal_offset_next     = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_HEADER;
            run_length_reg       <= 8'd0;
            literal_left_reg     <= 8'd0;
            literal_dropping_reg <= 1'b0;
            row_position_reg     <= 16'd0;
            literal_offset_reg   <= 8'd0;
        end
        else if (in_acc)
        begin
            phase_reg            <= phase_next;
            run_length_reg       <= run_length_next;
            literal_left_reg     <= literal_left_next;
            literal_dropping_reg <= literal_dropping_next;
            row_position_reg     <= row_position_next;
            literal_offset_reg   <= literal_offset_next;
        end
    end

    // result queue
    assign push_cnt   = in_acc ? ({2'd0, data_vld} + {2'd0, last}) : '0;
    assign count_next = count_reg + push_cnt - {2'd0, out_acc};

    assign in_ch.ready  = count_reg <= 3'(QUEUE_DEPTH - 2);
    assign out_ch.valid = count_reg != '0;
    assign out_ch.data  = queue_reg[head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            tail_reg  <= tail_reg + push_cnt[QUEUE_AW-1:0];
            if (out_acc)
            begin
                head_reg <= head_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (data_vld)
            begin
                queue_reg[tail_reg] <= data_word;
                if (last)
                begin
                    queue_reg[tail_reg + 2'd1] <= stat_word;
                end
            end
            else if (last)
            begin
                queue_reg[tail_reg] <= stat_word;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(QUEUE_DEPTH))
    else $error("result queue overrun");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && last |=> phase_reg == PH_HEADER && row_position_reg == 16'd0)
    else $error("row state not cleared after last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        literal_dropping_reg |-> phase_reg == PH_LITERAL)
    else $error("drop flag outside literal");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (out_ch.data.row_done == (out_ch.data.repeat_count == 8'd0)))
    else $error("status word and repeat count disagree");

endmodule
